[hw/rtl/interval_timer_bank_with_history_defines.svh]
`ifndef INTERVAL_TIMER_BANK_WITH_HISTORY_DEFINES_SVH
`define INTERVAL_TIMER_BANK_WITH_HISTORY_DEFINES_SVH

// Assertion helpers for the timer bank; clk and rst_n are taken from the
// module that uses them.

// Same-cycle implication
`define ITBH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itbh assertion failed");

// Next-cycle implication
`define ITBH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itbh assertion failed");

`endif

[hw/rtl/itbh_pkg.sv]
package itbh_pkg;

  // Field widths
  localparam int IDX_W      = 3;
  localparam int SLOT_W     = 4;
  localparam int TIME_W     = 30;
  localparam int STAT_W     = 3;
  localparam int REQ_W      = 2;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [TIME_W-1:0] NS_PER_SEC = 30'd1000000000;

  // Request types on the input channel
  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DUMP  = 2'd2;

  // Command kinds after classification
  localparam logic [KIND_W-1:0] CMD_START = 2'd0;
  localparam logic [KIND_W-1:0] CMD_STOP  = 2'd1;
  localparam logic [KIND_W-1:0] CMD_DUMP  = 2'd2;
  localparam logic [KIND_W-1:0] CMD_BAD   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_IDX = 3'd1;
  localparam logic [STAT_W-1:0] ST_RESTART = 3'd2;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd3;
  localparam logic [STAT_W-1:0] ST_MAX     = 3'd4;
  localparam logic [STAT_W-1:0] ST_SAMPLE  = 3'd5;
  localparam logic [STAT_W-1:0] ST_DONE    = 3'd6;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  timer;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] value;
    logic              last;
  } res_t;

endpackage

[hw/rtl/itbh_ram.sv]
module itbh_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 40,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/itbh_front.sv]
module itbh_front #(
  parameter int TIMERS = 4
) (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [itbh_pkg::REQ_W-1:0]         in_tuser,
  input  logic [itbh_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               q_full,
  output logic                               q_push,
  output itbh_pkg::cmd_t                     q_cmd
);
  import itbh_pkg::*;

  logic [IDX_W-1:0]  idx;
  logic [TIME_W-1:0] stamp;
  logic              idx_bad;
  logic              accept;

  assign idx   = in_tdata[IDX_W-1:0];
  assign stamp = in_tdata[IDX_W+TIME_W-1:IDX_W];

  // Take a request whenever the queue has room
  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign idx_bad   = ({1'b0, idx} >= (IDX_W+1)'(TIMERS));

  // Fold the stamp into the second and classify the request
  always_comb begin
    q_cmd.idx  = idx;
    q_cmd.now  = (stamp >= NS_PER_SEC) ? (stamp - NS_PER_SEC) : stamp;
    q_cmd.kind = CMD_BAD;
    q_push     = 1'b0;
    case (in_tuser)
      REQ_START: begin
        q_cmd.kind = idx_bad ? CMD_BAD : CMD_START;
        q_push     = accept;
      end
      REQ_STOP: begin
        q_cmd.kind = idx_bad ? CMD_BAD : CMD_STOP;
        q_push     = accept;
      end
      REQ_DUMP: begin
        q_cmd.kind = CMD_DUMP;
        q_push     = accept;
      end
      default: begin
        // drop the unused request type
        q_push = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/itbh_fifo.sv]
module itbh_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  itbh_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output itbh_pkg::cmd_t head
);
  import itbh_pkg::*;

  cmd_t           mem_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt;
  logic [QAW-1:0] rd_r, rd_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  // Advance pointers and fill count
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold the queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

[hw/rtl/itbh_back.sv]
`include "interval_timer_bank_with_history_defines.svh"

module itbh_back #(
  parameter int TIMERS  = 4,
  parameter int SAMPLES = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  itbh_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output itbh_pkg::res_t out_res
);
  import itbh_pkg::*;

  localparam int DEPTH = TIMERS * SAMPLES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TIW   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int TCW   = $clog2(TIMERS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STOP = 3'd1;
  localparam logic [2:0] S_DT   = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DEM  = 3'd4;

  // Per-timer state and ring valid bits
  logic              run_r   [TIMERS];
  logic [TIME_W-1:0] stamp_r [TIMERS];
  logic [SLOT_W-1:0] pos_r   [TIMERS];
  logic [TIME_W-1:0] max_r   [TIMERS];
  logic              vld_r   [DEPTH];

  logic [2:0]        state_r, state_nxt;
  logic [TCW-1:0]    t_r, t_nxt;
  logic [SLOT_W-1:0] s_r, s_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic              out_vld_r, out_vld_nxt;
  res_t              out_r, out_nxt;
  cmd_t              cur_r;
  logic [TIME_W-1:0] elapsed_r;
  logic              rd_vld_r;

  logic              out_free;
  logic              ld_out;
  logic              ld_stop;
  logic              do_start;
  logic              do_stop;
  logic              do_clear;
  logic [TIW-1:0]    hidx;
  logic [TIW-1:0]    cidx;
  logic [TIW-1:0]    tix;
  logic              t_done;
  logic [TIME_W:0]   diff;
  logic [TIME_W-1:0] elapsed_c;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic              ram_re;
  logic [TIME_W-1:0] ram_rdata;
  logic [SLOT_W-1:0] pos_next;

  assign out_free = !out_vld_r || out_ready;
  assign hidx     = q_head.idx[TIW-1:0];
  assign cidx     = cur_r.idx[TIW-1:0];
  assign tix      = t_r[TIW-1:0];
  assign t_done   = (t_r == TCW'(TIMERS));

  // Elapsed time modulo one second
  assign diff      = {1'b0, q_head.now} - {1'b0, stamp_r[hidx]};
  assign elapsed_c = diff[TIME_W] ? (diff[TIME_W-1:0] + NS_PER_SEC) : diff[TIME_W-1:0];

  assign wr_addr  = AW'(int'(cidx) * SAMPLES + int'(pos_r[cidx]));
  assign rd_addr  = base_r + AW'(s_r);
  assign pos_next = (pos_r[cidx] == SLOT_W'(SAMPLES - 1)) ? '0 : pos_r[cidx] + 1'b1;

  itbh_ram #(
    .WIDTH (TIME_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (do_stop),
    .waddr (wr_addr),
    .wdata (elapsed_r),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Sequencer: execute one command, or walk the dump
  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    s_nxt     = s_r;
    base_nxt  = base_r;
    out_nxt   = out_r;
    q_pop     = 1'b0;
    ld_out    = 1'b0;
    ld_stop   = 1'b0;
    do_start  = 1'b0;
    do_stop   = 1'b0;
    do_clear  = 1'b0;
    ram_re    = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          case (q_head.kind)
            CMD_START: begin
              if (out_free) begin
                q_pop    = 1'b1;
                do_start = 1'b1;
                ld_out   = 1'b1;
                out_nxt  = '{run_r[hidx] ? ST_RESTART : ST_OK, q_head.idx, '0, '0, 1'b1};
              end
            end
            CMD_STOP: begin
              if (!run_r[hidx]) begin
                if (out_free) begin
                  q_pop   = 1'b1;
                  ld_out  = 1'b1;
                  out_nxt = '{ST_IGNORED, q_head.idx, '0, '0, 1'b1};
                end
              end else begin
                q_pop     = 1'b1;
                ld_stop   = 1'b1;
                state_nxt = S_STOP;
              end
            end
            CMD_DUMP: begin
              q_pop     = 1'b1;
              t_nxt     = '0;
              base_nxt  = '0;
              state_nxt = S_DT;
            end
            default: begin
              if (out_free) begin
                q_pop   = 1'b1;
                ld_out  = 1'b1;
                out_nxt = '{ST_BAD_IDX, q_head.idx, '0, '0, 1'b1};
              end
            end
          endcase
        end
      end
      S_STOP: begin
        if (out_free) begin
          do_stop   = 1'b1;
          ld_out    = 1'b1;
          out_nxt   = '{ST_OK, cur_r.idx, '0, elapsed_r, 1'b1};
          state_nxt = S_IDLE;
        end
      end
      S_DT: begin
        if (t_done) begin
          if (out_free) begin
            ld_out    = 1'b1;
            do_clear  = 1'b1;
            out_nxt   = '{ST_DONE, '0, '0, '0, 1'b1};
            state_nxt = S_IDLE;
          end
        end else if (max_r[tix] == '0) begin
          // skip a timer with no record
          t_nxt    = t_r + 1'b1;
          base_nxt = base_r + AW'(SAMPLES);
        end else if (out_free) begin
          ld_out    = 1'b1;
          out_nxt   = '{ST_MAX, IDX_W'(t_r), '0, max_r[tix], 1'b0};
          s_nxt     = '0;
          state_nxt = S_DRD;
        end
      end
      S_DRD: begin
        ram_re    = 1'b1;
        state_nxt = S_DEM;
      end
      S_DEM: begin
        if (out_free) begin
          ld_out  = 1'b1;
          out_nxt = '{ST_SAMPLE, IDX_W'(t_r), s_r, rd_vld_r ? ram_rdata : '0, 1'b0};
          if (s_r == SLOT_W'(SAMPLES - 1)) begin
            t_nxt     = t_r + 1'b1;
            base_nxt  = base_r + AW'(SAMPLES);
            state_nxt = S_DT;
          end else begin
            s_nxt     = s_r + 1'b1;
            state_nxt = S_DRD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_vld_nxt = ld_out ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      t_r       <= '0;
      s_r       <= '0;
      base_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      t_r       <= t_nxt;
      s_r       <= s_nxt;
      base_r    <= base_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (ld_stop) begin
      cur_r     <= q_head;
      elapsed_r <= elapsed_c;
    end
    if (ram_re) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Timer state: clear on reset and after a dump
  always_ff @(posedge clk) begin
    if (!rst_n || do_clear) begin
      for (int i = 0; i < TIMERS; i++) begin
        run_r[i]   <= 1'b0;
        stamp_r[i] <= '0;
        pos_r[i]   <= '0;
        max_r[i]   <= '0;
      end
      for (int j = 0; j < DEPTH; j++) begin
        vld_r[j] <= 1'b0;
      end
    end else begin
      if (do_start) begin
        run_r[hidx]   <= 1'b1;
        stamp_r[hidx] <= q_head.now;
      end
      if (do_stop) begin
        run_r[cidx]    <= 1'b0;
        pos_r[cidx]    <= pos_next;
        vld_r[wr_addr] <= 1'b1;
        if (elapsed_r > max_r[cidx]) begin
          max_r[cidx] <= elapsed_r;
        end
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

  `ITBH_ASSERT_IMP(a_pop_only_idle, q_pop, state_r == S_IDLE)
  `ITBH_ASSERT_IMP(a_stop_on_running, state_r == S_STOP, run_r[cidx])
  `ITBH_ASSERT_NXT(a_read_then_emit, state_r == S_DRD, state_r == S_DEM)
  `ITBH_ASSERT_IMP(a_dump_rec_not_last, out_vld_r && (out_r.status == ST_MAX || out_r.status == ST_SAMPLE), !out_r.last)

endmodule

[hw/rtl/interval_timer_bank_with_history.sv]
// Start, invalid-index and ignored-stop requests: queued, then registered out, 1 per cycle
// unless the output stalls. Stop on a running timer: elapsed time is registered first, so stops
// do not issue back to back. Dump: timers without a record are skipped, each other gives its max
// record and each sample (ring RAM read), then the done record; input is held off once the
// 2-entry command queue fills. Reset (synchronous, rst_n low) and a finished dump clear all
// timer state at once through per-entry valid bits on the sample ring; no clearing pass.
module interval_timer_bank_with_history #(
  parameter int TIMERS  = 4,
  parameter int SAMPLES = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [itbh_pkg::REQ_W-1:0]         in_tuser,   // req_type
  input  logic [itbh_pkg::IN_DATA_W-1:0]     in_tdata,   // timer_index, timestamp_ns
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [itbh_pkg::STAT_W-1:0]        out_tuser,  // status
  output logic [itbh_pkg::OUT_DATA_W-1:0]    out_tdata,  // which_timer, sample_slot, time_value
  output logic                               out_tlast   // last_result
);
  import itbh_pkg::*;

  localparam int PAD_W = OUT_DATA_W - IDX_W - SLOT_W - TIME_W;

  cmd_t push_cmd;
  cmd_t head;
  logic push, pop, full, empty;
  res_t res;

  itbh_front #(
    .TIMERS (TIMERS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (full),
    .q_push    (push),
    .q_cmd     (push_cmd)
  );

  itbh_fifo u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  itbh_back #(
    .TIMERS  (TIMERS),
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (empty),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result onto the stream
  assign out_tuser = res.status;
  assign out_tdata = {{PAD_W{1'b0}}, res.value, res.slot, res.timer};
  assign out_tlast = res.last;

endmodule
